>>> hdl/platter_speed_pid_supervisor_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the platter speed PID supervisor unit.
// Each macro states a clocked property that is switched off while reset is low.
// ----------------------------------------------------------------------------
`ifndef PLATTER_SPEED_PID_SUPERVISOR_UNIT_ASSERT_SVH
`define PLATTER_SPEED_PID_SUPERVISOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/psps_pkg.sv
// ----------------------------------------------------------------------------
// Platter speed PID supervisor package
// Shared constants, codes and types of the platter speed PID supervisor unit.
// ----------------------------------------------------------------------------
package psps_pkg;

    localparam int ELAPSED_BITS_DEF = 10;

    localparam int SPEED_W = 16;
    localparam int GAIN_W  = 16;
    localparam int INTEG_W = 15;
    localparam int DRIVE_W = 16;

    localparam int I_START   = 7680;
    localparam int I_LOW     = 10240;
    localparam int I_HIGH    = 20480;
    localparam int DRIVE_LIM = 25600;

    localparam int SLOW_TICKS   = 300;
    localparam int SPINUP_TICKS = 150;
    localparam int SWING_TICKS  = 200;

    localparam logic [15:0] RATE_33_RST = 16'd8533;
    localparam logic [15:0] RATE_45_RST = 16'd11520;
    localparam logic [15:0] RATE_78_RST = 16'd19968;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_PLAY = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;
    localparam logic [1:0] MODE_SET  = 2'd3;

    localparam logic [1:0] SEL_45 = 2'd2;
    localparam logic [1:0] SEL_78 = 2'd3;

    localparam logic [2:0] ST_BAD_ORIENT = 3'd1;
    localparam logic [2:0] ST_HOME       = 3'd2;
    localparam logic [2:0] ST_HOMING     = 3'd3;
    localparam logic [2:0] ST_PARKING    = 3'd4;
    localparam logic [2:0] ST_CLEANING   = 3'd5;
    localparam logic [2:0] ST_HOME_PLAY  = 3'd6;

    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_AT_SPEED   = 3'd1;
    localparam logic [2:0] EV_HAND_STOP  = 3'd2;
    localparam logic [2:0] EV_NO_SPIN_UP = 3'd3;
    localparam logic [2:0] EV_STILL_TURN = 3'd4;
    localparam logic [2:0] EV_SWING      = 3'd5;
    localparam logic [2:0] EV_SPUN_DOWN  = 3'd6;

    localparam logic [1:0] REQ_NONE      = 2'd0;
    localparam logic [1:0] REQ_STOPPING  = 2'd1;
    localparam logic [1:0] REQ_HOMING    = 2'd2;
    localparam logic [1:0] REQ_HOME_PLAY = 2'd3;

    localparam logic [2:0] REG_GAIN_P   = 3'd0;
    localparam logic [2:0] REG_GAIN_I   = 3'd1;
    localparam logic [2:0] REG_GAIN_D   = 3'd2;
    localparam logic [2:0] REG_RATE_33  = 3'd3;
    localparam logic [2:0] REG_RATE_45  = 3'd4;
    localparam logic [2:0] REG_RATE_78  = 3'd5;
    localparam logic [2:0] REG_SUPERV   = 3'd6;
    localparam logic [2:0] REG_COMPENS  = 3'd7;

    typedef struct packed {
        logic [SPEED_W-1:0] target;
        logic [SPEED_W-1:0] speed;
        logic [SPEED_W-1:0] prev_speed;
        logic [INTEG_W-1:0] integ;
        logic [DRIVE_W-1:0] unbalance;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic               comp_en;
    } t_pid_in;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic [INTEG_W-1:0] integ;
    } t_pid_out;

endpackage

>>> hdl/psps_pid.sv
// ----------------------------------------------------------------------------
// Platter speed PID step
// One PID step with integrator clamping, unbalance term and drive saturation.
// ----------------------------------------------------------------------------
module psps_pid (
    input  psps_pkg::t_pid_in  i_pid,
    output psps_pkg::t_pid_out o_pid
);
    import psps_pkg::*;

    logic signed [16:0] err;
    logic signed [16:0] diff;
    logic signed [32:0] prod_p;
    logic signed [32:0] prod_i;
    logic signed [32:0] prod_d;
    logic signed [24:0] term_p;
    logic signed [24:0] term_i;
    logic signed [24:0] term_d;
    logic signed [25:0] integ_acc;
    logic [INTEG_W-1:0] integ_clamped;
    logic [INTEG_W-1:0] integ_used;
    logic signed [26:0] drive_sum;
    logic [DRIVE_W-1:0] drive_sat;

    assign err  = $signed({1'b0, i_pid.target}) - $signed({1'b0, i_pid.speed});
    assign diff = $signed({1'b0, i_pid.speed}) - $signed({1'b0, i_pid.prev_speed});

    assign prod_p = err * $signed(i_pid.gain_p);
    assign prod_i = err * $signed(i_pid.gain_i);
    assign prod_d = diff * $signed(i_pid.gain_d);

    assign term_p = i_pid.comp_en ? $signed(prod_p[32:8]) : 25'sd0;
    assign term_i = $signed(prod_i[32:8]);
    assign term_d = i_pid.comp_en ? $signed(prod_d[32:8]) : 25'sd0;

    assign integ_acc = $signed({11'd0, i_pid.integ}) + $signed({term_i[24], term_i});

    always_comb begin
        if (integ_acc < I_LOW) begin
            integ_clamped = INTEG_W'(I_LOW);
        end else if (integ_acc > I_HIGH) begin
            integ_clamped = INTEG_W'(I_HIGH);
        end else begin
            integ_clamped = integ_acc[INTEG_W-1:0];
        end
    end

    assign integ_used = i_pid.comp_en ? integ_clamped : i_pid.integ;

    assign drive_sum = $signed({{2{term_p[24]}}, term_p})
                     + $signed({{2{term_d[24]}}, term_d})
                     + $signed({12'd0, integ_used})
                     + $signed({{11{i_pid.unbalance[15]}}, i_pid.unbalance});

    always_comb begin
        if (drive_sum > DRIVE_LIM) begin
            drive_sat = DRIVE_W'(DRIVE_LIM);
        end else if (drive_sum < -DRIVE_LIM) begin
            drive_sat = DRIVE_W'(-DRIVE_LIM);
        end else begin
            drive_sat = drive_sum[DRIVE_W-1:0];
        end
    end

    assign o_pid.drive = drive_sat;
    assign o_pid.integ = integ_used;

endmodule

>>> hdl/platter_speed_pid_supervisor_unit.sv
// ----------------------------------------------------------------------------
// Platter speed PID supervisor unit
// Turntable motor speed controller with PID drive and a speed supervisor.
// ----------------------------------------------------------------------------
// Usage:
// Input items (a tick or a play, stop or set speed command) arrive on the
// i_in_valid/o_in_ready channel; one result item per input item leaves on
// the o_out_valid/i_out_ready channel.
// An accepted item is held in an input register; the PID step and the
// supervisor rules are then evaluated on it in one pass, and the result and
// the controller state are registered together once the result register can
// take the result.
// A new item is taken every cycle while the receiver does not stall; the
// feedback through the integrator, target and flag registers does not limit this.
// While the receiver stalls, the result register holds its item and the input
// register can still take one more item; further items then wait.
// Configuration registers are written through i_cfg_valid, i_cfg_index and
// i_cfg_data, always ready; the user must write only while idle, as the
// block does not enforce it. A synchronous reset empties both registers,
// clears the controller state and loads the default gains, rates and enables.
// ----------------------------------------------------------------------------
module platter_speed_pid_supervisor_unit #(
    parameter int ELAPSED_BITS = psps_pkg::ELAPSED_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [1:0]         i_rpm_select,
    input  logic [15:0]        i_speed_centered,
    input  logic [15:0]        i_speed_plain,
    input  logic signed [15:0] i_unbalance_term,
    input  logic [2:0]         i_sys_state,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_drive,
    output logic [2:0]         o_event_res,
    output logic [1:0]         o_state_request,
    output logic               o_motor_running,
    output logic               o_reached_speed,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import psps_pkg::*;

    localparam logic [ELAPSED_BITS-1:0] EL_MAX     = '1;
    localparam logic [ELAPSED_BITS-1:0] SLOW_CNT   = ELAPSED_BITS'(SLOW_TICKS);
    localparam logic [ELAPSED_BITS-1:0] SPINUP_CNT = ELAPSED_BITS'(SPINUP_TICKS);
    localparam logic [ELAPSED_BITS-1:0] SWING_CNT  = ELAPSED_BITS'(SWING_TICKS);

    logic [15:0] r_gain_p, r_gain_i, r_gain_d;
    logic [15:0] r_rate_33, r_rate_45, r_rate_78;
    logic        r_sup_en, r_comp_en;

    logic        r_in_vld;
    logic [1:0]  r_mode;
    logic [1:0]  r_sel;
    logic [15:0] r_spc;
    logic [15:0] r_spd;
    logic [15:0] r_unb;
    logic [2:0]  r_st;

    logic        r_mo, r_as, r_sd;
    logic [INTEG_W-1:0]      r_integ;
    logic [15:0]             r_prev;
    logic [15:0]             r_tgt;
    logic [ELAPSED_BITS-1:0] r_el;

    logic        n_mo, n_as, n_sd;
    logic [INTEG_W-1:0]      n_integ;
    logic [15:0]             n_prev;
    logic [15:0]             n_tgt;
    logic [ELAPSED_BITS-1:0] n_el;

    logic        r_out_vld;
    logic [15:0] r_drive;
    logic [2:0]  r_ev;
    logic [1:0]  r_req;
    logic        r_mo_out, r_as_out;

    logic [15:0] res_drive;
    logic [2:0]  res_ev;
    logic [1:0]  res_req;

    logic        advance;
    logic        do_stop, do_start;
    logic [15:0] sel_rate;
    logic [ELAPSED_BITS-1:0] el_inc;
    logic [25:0] spd_x10, spd_x20, spd_x100, spd_x1000;
    logic [25:0] tgt_x65, tgt_x95, r33_x666;
    logic        home_state;

    t_pid_in  pid_in;
    t_pid_out pid_out;

    assign advance     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p  <= '0;
            r_gain_i  <= '0;
            r_gain_d  <= '0;
            r_rate_33 <= RATE_33_RST;
            r_rate_45 <= RATE_45_RST;
            r_rate_78 <= RATE_78_RST;
            r_sup_en  <= 1'b1;
            r_comp_en <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GAIN_P:  r_gain_p  <= i_cfg_data;
                REG_GAIN_I:  r_gain_i  <= i_cfg_data;
                REG_GAIN_D:  r_gain_d  <= i_cfg_data;
                REG_RATE_33: r_rate_33 <= i_cfg_data;
                REG_RATE_45: r_rate_45 <= i_cfg_data;
                REG_RATE_78: r_rate_78 <= i_cfg_data;
                REG_SUPERV:  r_sup_en  <= i_cfg_data[0];
                REG_COMPENS: r_comp_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_mode <= i_mode;
            r_sel  <= i_rpm_select;
            r_spc  <= i_speed_centered;
            r_spd  <= i_speed_plain;
            r_unb  <= i_unbalance_term;
            r_st   <= i_sys_state;
        end
    end

    always_comb begin
        pid_in.target     = r_tgt;
        pid_in.speed      = r_spc;
        pid_in.prev_speed = r_prev;
        pid_in.integ      = r_integ;
        pid_in.unbalance  = r_unb;
        pid_in.gain_p     = r_gain_p;
        pid_in.gain_i     = r_gain_i;
        pid_in.gain_d     = r_gain_d;
        pid_in.comp_en    = r_comp_en;
    end

    psps_pid u_pid (
        .i_pid (pid_in),
        .o_pid (pid_out)
    );

    always_comb begin
        if (r_sel == SEL_45) begin
            sel_rate = r_rate_45;
        end else if (r_sel == SEL_78) begin
            sel_rate = r_rate_78;
        end else begin
            sel_rate = r_rate_33;
        end
    end

    assign el_inc     = (r_el != EL_MAX) ? r_el + 1'b1 : r_el;
    assign spd_x10    = 26'(r_spd) * 26'd10;
    assign spd_x20    = 26'(r_spd) * 26'd20;
    assign spd_x100   = 26'(r_spd) * 26'd100;
    assign spd_x1000  = 26'(r_spd) * 26'd1000;
    assign tgt_x65    = 26'(r_tgt) * 26'd65;
    assign tgt_x95    = 26'(r_tgt) * 26'd95;
    assign r33_x666   = 26'(r_rate_33) * 26'd666;
    assign home_state = (r_st == ST_HOME) || (r_st == ST_HOMING) || (r_st == ST_PARKING);

    always_comb begin
        n_mo      = r_mo;
        n_as      = r_as;
        n_sd      = r_sd;
        n_integ   = r_integ;
        n_prev    = r_prev;
        n_tgt     = r_tgt;
        n_el      = r_el;
        res_drive = '0;
        res_ev    = EV_NONE;
        res_req   = REQ_NONE;
        do_stop   = 1'b0;
        do_start  = 1'b0;

        unique case (r_mode)
            MODE_PLAY: begin
                do_start = 1'b1;
            end
            MODE_STOP: begin
                do_stop = 1'b1;
            end
            MODE_SET: begin
                if (sel_rate != r_tgt) begin
                    if (r_mo) begin
                        n_tgt = sel_rate;
                    end
                    n_el = '0;
                end
            end
            default: begin
                n_el = el_inc;
                if (r_mo) begin
                    n_prev    = r_spc;
                    n_integ   = pid_out.integ;
                    res_drive = pid_out.drive;
                end else begin
                    n_integ = '0;
                end
                if (r_sup_en && r_st != ST_CLEANING) begin
                    if (r_mo) begin
                        if (r_st == ST_BAD_ORIENT || r_st == ST_HOME) begin
                            res_ev  = EV_STILL_TURN;
                            do_stop = 1'b1;
                        end else if (r_as) begin
                            if (spd_x100 < tgt_x65 && el_inc > SLOW_CNT) begin
                                res_ev  = EV_HAND_STOP;
                                do_stop = 1'b1;
                            end
                        end else if (spd_x100 > tgt_x95) begin
                            res_ev = EV_AT_SPEED;
                            n_as   = 1'b1;
                        end else if (spd_x10 < 26'(r_tgt) && el_inc > SPINUP_CNT) begin
                            res_ev  = EV_NO_SPIN_UP;
                            do_stop = 1'b1;
                        end
                    end else if (el_inc > SWING_CNT && !r_sd && spd_x1000 > r33_x666
                                 && home_state) begin
                        res_ev   = EV_SWING;
                        do_start = 1'b1;
                    end else if (r_sd && spd_x20 < 26'(r_rate_33)) begin
                        n_sd   = 1'b0;
                        n_el   = '0;
                        res_ev = EV_SPUN_DOWN;
                    end
                end
            end
        endcase

        if (do_start) begin
            res_req = REQ_HOME_PLAY;
            n_mo    = 1'b1;
            n_integ = INTEG_W'(I_START);
            if (r_rate_33 != r_tgt) begin
                n_tgt = sel_rate;
                n_el  = '0;
            end
        end
        if (do_stop) begin
            res_req = (r_st == ST_HOME_PLAY) ? REQ_HOMING : REQ_STOPPING;
            n_mo    = 1'b0;
            n_tgt   = '0;
            n_el    = '0;
            n_sd    = 1'b1;
            n_as    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mo    <= 1'b0;
            r_as    <= 1'b0;
            r_sd    <= 1'b0;
            r_integ <= '0;
            r_prev  <= '0;
            r_tgt   <= '0;
            r_el    <= '0;
        end else if (advance) begin
            r_mo    <= n_mo;
            r_as    <= n_as;
            r_sd    <= n_sd;
            r_integ <= n_integ;
            r_prev  <= n_prev;
            r_tgt   <= n_tgt;
            r_el    <= n_el;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_drive  <= res_drive;
            r_ev     <= res_ev;
            r_req    <= res_req;
            r_mo_out <= n_mo;
            r_as_out <= n_as;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_drive         = r_drive;
    assign o_event_res     = r_ev;
    assign o_state_request = r_req;
    assign o_motor_running = r_mo_out;
    assign o_reached_speed = r_as_out;

endmodule

>>> hdl/psps_checker.sv
// ----------------------------------------------------------------------------
// Platter speed PID supervisor checker
// Port-level assertions on the result items of the unit, bound to the top.
// ----------------------------------------------------------------------------
`include "platter_speed_pid_supervisor_unit_assert.svh"

module psps_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] o_drive,
    input logic [2:0]         o_event_res,
    input logic [1:0]         o_state_request,
    input logic               o_motor_running,
    input logic               o_reached_speed
);
    import psps_pkg::*;

    logic        drive_ok;
    logic        start_ok;
    logic        stop_ok;
    logic        at_speed_ok;
    logic        stalled;
    logic [23:0] held;

    assign drive_ok    = (o_drive >= -DRIVE_LIM) && (o_drive <= DRIVE_LIM);
    assign start_ok    = (o_state_request != REQ_HOME_PLAY) || o_motor_running;
    assign stop_ok     = !((o_state_request == REQ_STOPPING) || (o_state_request == REQ_HOMING))
                         || (!o_motor_running && !o_reached_speed);
    assign at_speed_ok = (o_event_res != EV_AT_SPEED) || (o_motor_running && o_reached_speed);
    assign stalled     = o_out_valid && !i_out_ready;
    assign held        = {o_out_valid, o_drive, o_event_res, o_state_request,
                          o_motor_running, o_reached_speed};

    `PSPS_ASSERT_NOW(a_drive_rng, i_clk, i_rst_n, o_out_valid, drive_ok, "Drive out of range.")
    `PSPS_ASSERT_NOW(a_start_runs, i_clk, i_rst_n, o_out_valid, start_ok, "Motor not started.")
    `PSPS_ASSERT_NOW(a_stop_halts, i_clk, i_rst_n, o_out_valid, stop_ok, "Motor not stopped.")
    `PSPS_ASSERT_NOW(a_at_spd, i_clk, i_rst_n, o_out_valid, at_speed_ok, "Bad at-speed flags.")
    `PSPS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, stalled, $stable(held), "Item not held.")

endmodule

bind platter_speed_pid_supervisor_unit psps_checker u_psps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_drive         (o_drive),
    .o_event_res     (o_event_res),
    .o_state_request (o_state_request),
    .o_motor_running (o_motor_running),
    .o_reached_speed (o_reached_speed)
);
